// ===== rtl/dac_waveform_sound_device_defines.svh =====
// ----------------------------------------------------------------------------
// Sound DAC device assertion macros
// Shared assertion forms for the sound DAC device, clocked on aclk and held
// off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef DAC_WAVEFORM_SOUND_DEVICE_DEFINES_SVH
`define DAC_WAVEFORM_SOUND_DEVICE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DWSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DWSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dwsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Sound DAC device package
// Request codes, register offsets, mode codes and constants of the sound DAC.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dwsd_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_TICK  = 2'd2
    } command_t;

    typedef enum logic [1:0] {
        DMA_NONE  = 2'd0,
        DMA_READ  = 2'd1,
        DMA_WRITE = 2'd2
    } dma_cycle_t;

    localparam logic [1:0] PORT_CONTROL = 2'd0;
    localparam logic [1:0] PORT_WAVE    = 2'd1;
    localparam logic [1:0] PORT_FREQ_LO = 2'd2;
    localparam logic [1:0] PORT_FREQ_HI = 2'd3;

    localparam logic [1:0] MODE_JOYSTICK = 2'd0;
    localparam logic [1:0] MODE_WAVE     = 2'd1;
    localparam logic [1:0] MODE_DMA      = 2'd2;
    localparam logic [1:0] MODE_DAC      = 2'd3;

    localparam logic [1:0] WAVE_PULSE    = 2'd0;
    localparam logic [1:0] WAVE_RAMP     = 2'd1;
    localparam logic [1:0] WAVE_TRIANGLE = 2'd2;

    localparam logic [7:0]  DAC_MIDPOINT   = 8'h80;
    localparam logic [11:0] DEFAULT_RELOAD = 12'h400;

    // ceil(2^19 / 15); with the factor 32 folded in, the shift becomes 14.
    localparam logic [15:0] RECIP_15    = 16'h8889;
    localparam int          RECIP_SHIFT = 14;

endpackage

// ===== rtl/dac_waveform_sound_device.sv =====
// ----------------------------------------------------------------------------
// Sound DAC device
// Four byte registers, a period timer driving a waveform generator or DMA
// transfers, and a scaled signed sample output.
// ----------------------------------------------------------------------------
// Usage: each request on the s_ channel is a bus write, a bus read or one tick
// of the 3.579545 MHz reference, selected by s_tuser. Every accepted request
// yields exactly one result on the m_ channel, carrying the read byte, the
// interrupt line, the sample after the step, the DMA cycle kind and the timer
// expiry flag.
// The result is registered: a request accepted at a clock edge has its result valid
// right after that edge. Throughput is one request per cycle unless the receiver stalls;
// the register state and the sample scaling settle in a single pass of logic between the
// registers and the result register.
// The result register parts the two sides: s_tready stays high while the
// result register is empty or being taken, so a stalled receiver holds one
// result and blocks new requests only while it stalls.
// Reset clears all device registers, the timer and the waveform position,
// and empties the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dac_waveform_sound_device_defines.svh"

module dac_waveform_sound_device (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Bits from 0: port[1:0], write_data[9:2], dma_data[17:10],
    // dma_has_data[18], dma_terminal[19], zero fill[23:20].
    input  logic [23:0] s_tdata,
    // Bits from 0: command[1:0].
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Bits from 0: read_data[7:0], irq_line[8], sample[21:9],
    // dma_cycle[23:22], timer_fired[24], zero fill[31:25].
    output logic [31:0] m_tdata
);

    logic [7:0]  control_reg, control_next;
    logic [7:0]  wave_reg, wave_next;
    logic [7:0]  dac_reg, dac_next;
    logic [11:0] freq_reg, freq_next;
    logic [3:0]  amp_reg, amp_next;
    logic        irq_pending_reg, irq_pending_next;
    logic        timer_enabled_reg, timer_enabled_next;
    logic [11:0] period_reg, period_next;
    logic [4:0]  position_reg, position_next;

    logic        m_valid_reg;
    logic [7:0]  read_data_reg, read_data_next;
    logic        irq_line_reg, irq_line_next;
    logic [12:0] sample_reg, sample_next;
    logic [1:0]  dma_cycle_reg, dma_cycle_next;
    logic        fired_reg, fired_next;

    logic        accept;
    logic [1:0]  in_command;
    logic [1:0]  in_port;
    logic [7:0]  in_wdata;
    logic [7:0]  in_ddata;
    logic        in_has_data;
    logic        in_terminal;
    logic [11:0] reload;
    logic [7:0]  wave_value;
    logic        enable_req;

    logic [7:0]  dac_offset;
    logic [7:0]  magnitude;
    logic [11:0] product;
    logic [26:0] scaled;
    logic [13:0] quotient;
    logic [13:0] signed_sample;

    assign in_command  = s_tuser[1:0];
    assign in_port     = s_tdata[1:0];
    assign in_wdata    = s_tdata[9:2];
    assign in_ddata    = s_tdata[17:10];
    assign in_has_data = s_tdata[18];
    assign in_terminal = s_tdata[19];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign reload     = (freq_reg == 12'd0) ? dwsd_pkg::DEFAULT_RELOAD : freq_reg;
    assign enable_req = in_wdata[2] && (in_wdata[1:0] != dwsd_pkg::MODE_JOYSTICK);

    always_comb begin
        case (wave_reg[7:6])
            dwsd_pkg::WAVE_PULSE: begin
                wave_value = (position_reg > {1'b0, wave_reg[2:0], 1'b0}) ? 8'hff : 8'h00;
            end
            dwsd_pkg::WAVE_RAMP: begin
                wave_value = {position_reg, 3'b000};
            end
            dwsd_pkg::WAVE_TRIANGLE: begin
                wave_value = position_reg[4] ? {~position_reg[3:0], 4'h0}
                                             : {position_reg[3:0], 4'h0};
            end
            default: begin
                wave_value = dwsd_pkg::DAC_MIDPOINT;
            end
        endcase
    end

    always_comb begin
        control_next       = control_reg;
        wave_next          = wave_reg;
        dac_next           = dac_reg;
        freq_next          = freq_reg;
        amp_next           = amp_reg;
        irq_pending_next   = irq_pending_reg;
        timer_enabled_next = timer_enabled_reg;
        period_next        = period_reg;
        position_next      = position_reg;
        read_data_next     = 8'h00;
        dma_cycle_next     = dwsd_pkg::DMA_NONE;
        fired_next         = 1'b0;

        case (in_command)
            dwsd_pkg::CMD_WRITE: begin
                case (in_port)
                    dwsd_pkg::PORT_CONTROL: begin
                        control_next = in_wdata;
                        if (!timer_enabled_reg && enable_req) begin
                            period_next = reload;
                        end
                        timer_enabled_next = enable_req;
                        if (!in_wdata[3]) begin
                            irq_pending_next = 1'b0;
                        end
                    end
                    dwsd_pkg::PORT_WAVE: begin
                        if (control_reg[1:0] == dwsd_pkg::MODE_WAVE) begin
                            wave_next = in_wdata;
                        end else if (control_reg[1:0] == dwsd_pkg::MODE_DAC) begin
                            dac_next = in_wdata;
                        end
                    end
                    dwsd_pkg::PORT_FREQ_LO: begin
                        freq_next = {freq_reg[11:8], in_wdata};
                    end
                    default: begin
                        freq_next = {in_wdata[3:0], freq_reg[7:0]};
                        amp_next  = in_wdata[7:4];
                    end
                endcase
            end
            dwsd_pkg::CMD_READ: begin
                case (in_port)
                    dwsd_pkg::PORT_CONTROL: begin
                        read_data_next = {1'b0, control_reg[6:4], irq_pending_reg,
                                          control_reg[2:0]};
                    end
                    dwsd_pkg::PORT_WAVE: begin
                        case (control_reg[1:0])
                            dwsd_pkg::MODE_JOYSTICK: read_data_next = 8'h00;
                            dwsd_pkg::MODE_WAVE:     read_data_next = wave_reg;
                            dwsd_pkg::MODE_DMA:      read_data_next = dwsd_pkg::DAC_MIDPOINT;
                            default:                 read_data_next = dac_reg;
                        endcase
                    end
                    dwsd_pkg::PORT_FREQ_LO: begin
                        read_data_next = freq_reg[7:0];
                    end
                    default: begin
                        read_data_next = {amp_reg, freq_reg[11:8]};
                    end
                endcase
            end
            dwsd_pkg::CMD_TICK: begin
                if (timer_enabled_reg) begin
                    if (period_reg <= 12'd1) begin
                        fired_next  = 1'b1;
                        period_next = reload;
                        if (control_reg[1]) begin
                            if (control_reg[1:0] == dwsd_pkg::MODE_DAC) begin
                                dma_cycle_next = dwsd_pkg::DMA_READ;
                                if (in_has_data) begin
                                    dac_next = in_ddata;
                                end
                            end else begin
                                dma_cycle_next = dwsd_pkg::DMA_WRITE;
                            end
                            if (in_has_data && in_terminal && control_reg[3]) begin
                                irq_pending_next = 1'b1;
                            end
                        end else begin
                            dac_next      = wave_value;
                            position_next = position_reg + 5'd1;
                        end
                    end else begin
                        period_next = period_reg - 12'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Truncation toward zero is done on the magnitude, then the sign is restored.
    assign dac_offset    = dac_next ^ dwsd_pkg::DAC_MIDPOINT;
    assign magnitude     = dac_offset[7] ? (~dac_offset + 8'd1) : dac_offset;
    assign product       = {4'd0, magnitude} * {8'd0, amp_next};
    assign scaled        = {15'd0, product} * {11'd0, dwsd_pkg::RECIP_15};
    assign quotient      = {1'b0, scaled[dwsd_pkg::RECIP_SHIFT +: 13]};
    assign signed_sample = dac_offset[7] ? (~quotient + 14'd1) : quotient;
    assign sample_next   = signed_sample[12:0];

    assign irq_line_next = irq_pending_next && control_next[4] && control_next[3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            control_reg       <= 8'h00;
            wave_reg          <= 8'h00;
            dac_reg           <= 8'h00;
            freq_reg          <= 12'd0;
            amp_reg           <= 4'd0;
            irq_pending_reg   <= 1'b0;
            timer_enabled_reg <= 1'b0;
            period_reg        <= 12'd0;
            position_reg      <= 5'd0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (accept) begin
                control_reg       <= control_next;
                wave_reg          <= wave_next;
                dac_reg           <= dac_next;
                freq_reg          <= freq_next;
                amp_reg           <= amp_next;
                irq_pending_reg   <= irq_pending_next;
                timer_enabled_reg <= timer_enabled_next;
                period_reg        <= period_next;
                position_reg      <= position_next;
                m_valid_reg       <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            read_data_reg <= read_data_next;
            irq_line_reg  <= irq_line_next;
            sample_reg    <= sample_next;
            dma_cycle_reg <= dma_cycle_next;
            fired_reg     <= fired_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, fired_reg, dma_cycle_reg, sample_reg, irq_line_reg, read_data_reg};

    `DWSD_ASSERT_NOW(a_enable_needs_mode, timer_enabled_reg,
        control_reg[1:0] != dwsd_pkg::MODE_JOYSTICK, "timer enabled in joystick mode")
    `DWSD_ASSERT_NOW(a_period_nonzero, timer_enabled_reg, period_reg != 12'd0,
        "running timer holds a zero period count")
    `DWSD_ASSERT_NOW(a_dma_needs_fire, m_valid_reg && (dma_cycle_reg != dwsd_pkg::DMA_NONE),
        fired_reg, "DMA cycle reported without a timer expiry")
    `DWSD_ASSERT_NEXT(a_read_only_data, accept && (in_command != dwsd_pkg::CMD_READ),
        read_data_reg == 8'h00, "read data reported for a request that is not a read")

endmodule
